>>> rtl/lbvd_pkg.sv
// shared constants, register codes and helpers for the label boundary voxel detector
package lbvd_pkg;

  // default grid limits and label storage width
  localparam int DEF_MAX_X      = 512;
  localparam int DEF_MAX_Y      = 512;
  localparam int DEF_MAX_Z      = 512;
  localparam int DEF_LABEL_BITS = 32;

  // fixed port widths
  localparam int LABEL_W   = 32;
  localparam int INDEX_W   = 27;
  localparam int SIZE_W    = 10;
  localparam int CFG_IDX_W = 2;

  // size registers come out of reset at this extent (before clamping)
  localparam int SIZE_RESET = 512;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_t;

  // larger of two elaboration-time integers
  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int max_v);
    if (v == '0) begin
      return SIZE_W'(1);
    end
    if (int'(v) > max_v) begin
      return SIZE_W'(max_v);
    end
    return v;
  endfunction

endpackage

>>> rtl/label_boundary_voxel_detect_3d.sv
// top level: six-neighbour label boundary detector over a raster-ordered 3d label volume
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | in        | in_valid / in_ready    | label
//  out     | out       | out_valid / out_ready  | boundary_label, voxel_index
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one voxel per cycle while in_ready is high; the window store has one write port, and
// that port takes the write-back of each voxel.
// a report is registered into the output queue when its voxel is taken.
// reset clears position and the output queue and loads the reset sizes; window and row
// stores keep whatever they hold and need no clearing pass.
// in_ready falls only while the two-entry output queue is full.
module label_boundary_voxel_detect_3d
  import lbvd_pkg::*;
#(
  parameter int MAX_X      = DEF_MAX_X,
  parameter int MAX_Y      = DEF_MAX_Y,
  parameter int MAX_Z      = DEF_MAX_Z,
  parameter int LABEL_BITS = DEF_LABEL_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [LABEL_W-1:0]   label,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LABEL_W-1:0]   boundary_label,
  output logic [INDEX_W-1:0]   voxel_index,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  localparam int XW        = $clog2(MAX_X);
  localparam int YW        = $clog2(MAX_Y);
  localparam int ZW        = $clog2(MAX_Z);
  localparam int LW        = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;
  localparam int AW        = XW + YW;
  localparam int WIN_DEPTH = 2 ** AW;
  localparam int ROW_DEPTH = 2 ** XW;
  localparam int EW        = max_int(max_int(XW, YW), max_int(ZW, SIZE_W)) + 2;
  localparam int PW        = 2 * SIZE_W;

  // configuration and raster position
  logic [SIZE_W-1:0]  size_x, size_y, size_z;
  logic [XW-1:0]      pos_x;
  logic [YW-1:0]      pos_y;
  logic [ZW-1:0]      pos_z;
  logic [INDEX_W-1:0] lin;
  logic [PW-1:0]      plane_size;

  // window store: each word holds {newest plane label, plane before it} for one column
  logic [2*LW-1:0] win_mem [WIN_DEPTH];
  // row store: centre-plane labels of the previous row
  logic [LW-1:0]   row_mem [ROW_DEPTH];

  // prefetched window words and neighbour labels
  logic [2*LW-1:0] win_cur, win_ahead, row_cur, row_ahead;
  logic [LW-1:0]   up_label, left_label;

  // output queue
  logic [1:0]         out_cnt;
  logic [LABEL_W-1:0] slot0_label, slot1_label;
  logic [INDEX_W-1:0] slot0_idx, slot1_idx;

  logic               in_acc, cfg_acc, cfg_hit, pop, push;
  logic [LW-1:0]      cur_label, centre, below, right_label, down_label;
  logic [EW-1:0]      xe, ye, ze, sxe, sye, sze;
  logic               x_last, y_last, z_last, x_wrap2, interior, edge_hit;
  logic [XW-1:0]      ahead_x, step_x;
  logic [YW-1:0]      ahead_y, ahead_row_y;
  logic [LABEL_W-1:0] new_label;
  logic [INDEX_W-1:0] new_idx;

  // handshakes
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_ready  = (out_cnt != 2'd2);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (out_cnt != 2'd0);
  assign pop       = out_valid && out_ready;

  always_comb begin
    case (cfg_reg_t'(cfg_index))
      REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: cfg_hit = 1'b1;
      default:                            cfg_hit = 1'b0;
    endcase
  end

  // stencil labels
  assign cur_label   = label[LW-1:0];
  assign centre      = win_cur[2*LW-1:LW];
  assign below       = win_cur[LW-1:0];
  assign right_label = win_ahead[2*LW-1:LW];
  assign down_label  = row_cur[2*LW-1:LW];

  // position arithmetic in a common width
  assign xe  = EW'(pos_x);
  assign ye  = EW'(pos_y);
  assign ze  = EW'(pos_z);
  assign sxe = EW'(size_x);
  assign sye = EW'(size_y);
  assign sze = EW'(size_z);

  assign x_last = (xe + EW'(1)) >= sxe;
  assign y_last = (ye + EW'(1)) >= sye;
  assign z_last = (ze + EW'(1)) >= sze;

  // in-plane address two voxels ahead, and the row below it
  always_comb begin
    x_wrap2 = (xe + EW'(2)) >= sxe;
    if (x_wrap2) begin
      ahead_x = XW'(xe + EW'(2) - sxe);
      ahead_y = y_last ? '0 : YW'(ye + EW'(1));
    end else begin
      ahead_x = XW'(xe + EW'(2));
      ahead_y = pos_y;
    end
    ahead_row_y = YW'(ahead_y + YW'(1));
    step_x      = x_last ? '0 : XW'(xe + EW'(1));
  end

  // boundary decision for the centre voxel one plane back
  assign interior = (ze >= EW'(2)) && (xe >= EW'(1)) && ((xe + EW'(2)) <= sxe)
                 && (ye >= EW'(1)) && ((ye + EW'(2)) <= sye);
  assign edge_hit = (cur_label != centre) || (below != centre)
                 || (left_label != centre) || (right_label != centre)
                 || (up_label != centre) || (down_label != centre);
  assign push      = in_acc && interior && edge_hit;
  assign new_label = LABEL_W'(centre);
  assign new_idx   = lin - INDEX_W'(plane_size);

  // plane size for the index offset
  always_ff @(posedge clk) begin
    plane_size <= PW'(size_x) * PW'(size_y);
  end

  // size registers and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= clamp_size(SIZE_W'(SIZE_RESET), MAX_X);
      size_y <= clamp_size(SIZE_W'(SIZE_RESET), MAX_Y);
      size_z <= clamp_size(SIZE_W'(SIZE_RESET), MAX_Z);
      pos_x  <= '0;
      pos_y  <= '0;
      pos_z  <= '0;
      lin    <= '0;
    end else if (cfg_acc && cfg_hit) begin
      case (cfg_reg_t'(cfg_index))
        REG_SIZE_X: size_x <= clamp_size(cfg_data, MAX_X);
        REG_SIZE_Y: size_y <= clamp_size(cfg_data, MAX_Y);
        REG_SIZE_Z: size_z <= clamp_size(cfg_data, MAX_Z);
        default:    size_x <= size_x;
      endcase
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
      lin   <= '0;
    end else if (in_acc) begin
      if (x_last) begin
        pos_x <= '0;
        if (y_last) begin
          pos_y <= '0;
          pos_z <= z_last ? '0 : ZW'(ze + EW'(1));
        end else begin
          pos_y <= YW'(ye + EW'(1));
        end
      end else begin
        pos_x <= XW'(xe + EW'(1));
      end
      lin <= (x_last && y_last && z_last) ? '0 : lin + INDEX_W'(1);
    end
  end

  // window store: write back this column, prefetch two voxels ahead on both rows
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_mem[{pos_y, pos_x}] <= {cur_label, centre};
      win_ahead <= win_mem[{ahead_y, ahead_x}];
      row_ahead <= win_mem[{ahead_row_y, ahead_x}];
    end
  end

  // row store: keep the centre plane of this row, fetch the previous row's next entry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_mem[pos_x] <= centre;
      up_label       <= row_mem[step_x];
    end
  end

  // prefetch pipeline advance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_cur    <= win_ahead;
      row_cur    <= row_ahead;
      left_label <= centre;
    end
  end

  // two-entry output queue, control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else if (push && !pop) begin
      out_cnt <= out_cnt + 2'd1;
    end else if (pop && !push) begin
      out_cnt <= out_cnt - 2'd1;
    end
  end

  // two-entry output queue, payload
  always_ff @(posedge clk) begin
    if (pop) begin
      slot0_label <= slot1_label;
      slot0_idx   <= slot1_idx;
    end
    if (push) begin
      if ((out_cnt == 2'd0) || (pop && (out_cnt == 2'd1))) begin
        slot0_label <= new_label;
        slot0_idx   <= new_idx;
      end else begin
        slot1_label <= new_label;
        slot1_idx   <= new_idx;
      end
    end
  end

  assign boundary_label = slot0_label;
  assign voxel_index    = slot0_idx;

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    out_cnt != 2'd3)
    else $error("output queue count out of range");

  // a report only ever comes from an interior centre at least two planes in
  a_push_interior: assert property (@(posedge clk) disable iff (rst)
    push |-> (pos_z >= ZW'(2)) && (pos_x != '0) && (pos_y != '0))
    else $error("report raised for a non-interior voxel");

  // a valid register write restarts the volume
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_acc && ((cfg_index == REG_SIZE_X) || (cfg_index == REG_SIZE_Y)
                || (cfg_index == REG_SIZE_Z))
    |=> (pos_x == '0) && (pos_y == '0) && (pos_z == '0) && (lin == '0))
    else $error("register write did not restart the volume");

  // raster position stays inside the grid
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (xe < sxe) && (ye < sye) && (ze < sze))
    else $error("raster position outside the grid");

endmodule

>>> tb/tb_label_boundary_voxel_detect_3d.sv
// testbench for the 3d label boundary voxel detector: streamed volumes checked against a predictor
module tb_label_boundary_voxel_detect_3d
  import lbvd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int RANDOM_VOXELS = 1950;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 4;

  // write to an index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {FILL_NOISE, FILL_BLOCKS, FILL_RANDOM} fill_t;

  typedef struct packed {
    logic [LABEL_W-1:0] lbl;
    logic [INDEX_W-1:0] idx;
  } boundary_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [LABEL_W-1:0]   label = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [LABEL_W-1:0]   boundary_label;
  logic [INDEX_W-1:0]   voxel_index;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SIZE_X;
  logic [SIZE_W-1:0]    cfg_data = '0;

  // predictor state
  logic [LABEL_W-1:0] label_window [int];
  int unsigned        ext_x = DEF_MAX_X;
  int unsigned        ext_y = DEF_MAX_Y;
  int unsigned        ext_z = DEF_MAX_Z;
  int unsigned        col = 0;
  int unsigned        row = 0;
  int unsigned        plane = 0;
  boundary_t          boundary_q [$];

  int unsigned errors = 0;
  int unsigned voxels_sent = 0;
  int unsigned cycles = 0;
  bit          tx_smooth = 1'b0;
  bit          rx_smooth = 1'b0;
  int unsigned hold_ask = 0;
  int unsigned hold_done = 0;
  int unsigned rx_left = 0;
  bit          rx_stalled = 1'b1;

  label_boundary_voxel_detect_3d uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .label         (label),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .boundary_label(boundary_label),
    .voxel_index   (voxel_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // zero acts as one, anything past the grid limit acts as the limit
  function automatic int unsigned effective_extent(input logic [SIZE_W-1:0] v,
                                                   input int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // window address: one plane per parity, x fastest
  function automatic int win_slot(input int unsigned z, input int unsigned x,
                                  input int unsigned y);
    return ((z % 2) * DEF_MAX_Y + y) * DEF_MAX_X + x;
  endfunction

  // register write as the block sees it: any real register restarts the raster
  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] v);
    case (idx)
      REG_SIZE_X: ext_x = effective_extent(v, DEF_MAX_X);
      REG_SIZE_Y: ext_y = effective_extent(v, DEF_MAX_Y);
      REG_SIZE_Z: ext_z = effective_extent(v, DEF_MAX_Z);
      default: ;
    endcase
    if (idx != REG_UNUSED) begin
      col   = 0;
      row   = 0;
      plane = 0;
    end
  endtask

  // one voxel in: the centre one plane back is reported if interior and on a boundary
  task automatic predict_voxel(input logic [LABEL_W-1:0] cur);
    int unsigned       zc;
    logic [LABEL_W-1:0] c;
    bit                differs;
    longint unsigned   lin;
    boundary_t         b;
    if (plane >= 2 && col >= 1 && col + 2 <= ext_x && row >= 1 && row + 2 <= ext_y) begin
      zc = plane - 1;
      c  = label_window[win_slot(zc, col, row)];
      differs = (cur != c)
        || (label_window[win_slot(plane, col, row)] != c)
        || (label_window[win_slot(zc, col - 1, row)] != c)
        || (label_window[win_slot(zc, col + 1, row)] != c)
        || (label_window[win_slot(zc, col, row - 1)] != c)
        || (label_window[win_slot(zc, col, row + 1)] != c);
      if (differs) begin
        lin   = longint'(zc) * ext_x * ext_y + longint'(row) * ext_x + col;
        b.lbl = c;
        b.idx = lin[INDEX_W-1:0];
        boundary_q.push_back(b);
      end
    end
    label_window[win_slot(plane, col, row)] = cur;
    // raster advance with wrap at the end of the volume
    col++;
    if (col >= ext_x) begin
      col = 0;
      row++;
      if (row >= ext_y) begin
        row = 0;
        plane++;
        if (plane >= ext_z) plane = 0;
      end
    end
  endtask

  // compare one report with the oldest expectation
  task automatic check_report();
    boundary_t want;
    if (boundary_q.size() == 0) begin
      $display("%0t: unexpected report, expected none, actual label %h index %0d",
               $time, boundary_label, voxel_index);
      errors++;
    end else begin
      want = boundary_q.pop_front();
      if (boundary_label !== want.lbl) begin
        $display("%0t: boundary_label mismatch, expected %h, actual %h",
                 $time, want.lbl, boundary_label);
        errors++;
      end
      if (voxel_index !== want.idx) begin
        $display("%0t: voxel_index mismatch, expected %0d, actual %0d",
                 $time, want.idx, voxel_index);
        errors++;
      end
    end
  endtask

  // monitor: every accepted transaction on the three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) predict_voxel(label);
      if (out_valid && out_ready) check_report();
    end
  end

  // receiver: random ready and stall stretches, plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_ask != hold_done) begin
      hold_done  <= hold_ask;
      out_ready  <= 1'b0;
      rx_stalled <= 1'b1;
      rx_left    <= HOLD_CYCLES;
    end else if (rx_left > 1) begin
      rx_left <= rx_left - 1;
    end else if (rx_stalled || rx_smooth) begin
      out_ready  <= 1'b1;
      rx_stalled <= 1'b0;
      rx_left    <= rx_smooth ? 1 : $urandom_range(1, 24);
    end else begin
      out_ready  <= 1'b0;
      rx_stalled <= 1'b1;
      rx_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    end
  end

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (tx_smooth) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one voxel and hold it until the transaction completes
  task automatic send_voxel(input logic [LABEL_W-1:0] v);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    label    <= v;
    do @(posedge clk); while (!in_ready);
    voxels_sent++;
  endtask

  // sender pause until every expected report is out, then a short drain wait
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (boundary_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] v);
    repeat ($urandom_range(1, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_extents(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                             input logic [SIZE_W-1:0] sz);
    settle();
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
  endtask

  // stream voxels in raster order from the origin, wrapping into further volumes
  task automatic stream_volume(input int unsigned nx, input int unsigned ny,
                               input int unsigned nz, input int unsigned count,
                               input fill_t fill);
    int unsigned        x, y, z, n, pal_n, cut_x, cut_y, cut_z;
    logic [1:0]         sel;
    logic [LABEL_W-1:0] v;
    logic [LABEL_W-1:0] palette [4];
    x = 0;
    y = 0;
    z = 0;
    pal_n = $urandom_range(1, 4);
    cut_x = $urandom_range(0, nx);
    cut_y = $urandom_range(0, ny);
    cut_z = $urandom_range(0, nz);
    foreach (palette[i]) begin
      case ($urandom_range(0, 5))
        0:       palette[i] = '0;
        1:       palette[i] = '1;
        default: palette[i] = $urandom;
      endcase
    end
    for (n = 0; n < count; n++) begin
      case (fill)
        FILL_NOISE: v = palette[$urandom_range(0, pal_n - 1)];
        FILL_BLOCKS: begin
          sel = {y >= cut_y, x >= cut_x} + ((z >= cut_z) ? 2'd1 : 2'd0);
          v   = ($urandom_range(0, 24) == 0) ? palette[$urandom_range(0, 3)] : palette[sel];
        end
        default: v = $urandom;
      endcase
      // occasional mid-volume pause until the output has caught up
      if ($urandom_range(0, 199) == 0) settle();
      send_voxel(v);
      x++;
      if (x >= nx) begin
        x = 0;
        y++;
        if (y >= ny) begin
          y = 0;
          z++;
          if (z >= nz) z = 0;
        end
      end
    end
  endtask

  // reset extents are the largest grid: first plane only, nothing reported
  task automatic test_reset_extents();
    send_voxel('0);
    send_voxel('1);
    send_voxel(32'hAAAA_AAAA);
    send_voxel(32'h5555_5555);
    send_voxel($urandom);
  endtask

  // smallest grid: one interior voxel, reported when it differs, silent when uniform
  task automatic test_single_interior();
    set_extents(10'd3, 10'd3, 10'd3);
    for (int n = 0; n < 27; n++) send_voxel((n == 13) ? '1 : '0);
    // second volume after the wrap, all one label
    for (int n = 0; n < 27; n++) send_voxel(32'h0000_0007);
  endtask

  // write to an unused index mid-volume: raster position carries on
  task automatic test_unused_index();
    set_extents(10'd3, 10'd3, 10'd3);
    for (int n = 0; n < 13; n++) send_voxel(32'h8000_0001);
    settle();
    write_reg(REG_UNUSED, 10'h3FF);
    for (int n = 13; n < 27; n++) send_voxel((n == 14) ? 32'h0000_0002 : 32'h8000_0001);
  endtask

  // zero and undersized extents leave no interior voxel
  task automatic test_degenerate_extents();
    set_extents(10'd0, 10'h3FF, 10'd2);
    stream_volume(1, DEF_MAX_Y, 2, 60, FILL_RANDOM);
    set_extents(10'd2, 10'd2, 10'h3FF);
    stream_volume(2, 2, DEF_MAX_Z, 40, FILL_RANDOM);
  endtask

  // register write mid-volume restarts the raster but keeps the window
  task automatic test_restart_mid_volume();
    set_extents(10'd4, 10'd4, 10'd4);
    stream_volume(4, 4, 4, 40, FILL_NOISE);
    settle();
    write_reg(REG_SIZE_X, 10'd4);
    stream_volume(4, 4, 4, 64, FILL_BLOCKS);
  endtask

  // largest extent on each axis in turn, the others at three
  task automatic test_largest_extents();
    set_extents(10'h3FF, 10'd3, 10'd3);
    stream_volume(DEF_MAX_X, 3, 3, DEF_MAX_X * 9, FILL_BLOCKS);
    set_extents(10'd3, 10'd512, 10'd3);
    stream_volume(3, DEF_MAX_Y, 3, DEF_MAX_Y * 9, FILL_NOISE);
    set_extents(10'd3, 10'd3, 10'h3FF);
    stream_volume(3, 3, DEF_MAX_Z, DEF_MAX_Z * 9 + 9, FILL_NOISE);
  endtask

  // long receiver hold while the sender keeps going, so the block fills and stalls
  task automatic test_backpressure();
    set_extents(10'd6, 10'd6, 10'd6);
    tx_smooth = 1'b1;
    hold_ask++;
    stream_volume(6, 6, 6, 216, FILL_RANDOM);
    tx_smooth = 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_extent();
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 2);
    return $urandom_range(3, 6);
  endfunction

  // random grids, fills and volume counts, some volumes cut short
  task automatic test_random_volumes();
    logic [SIZE_W-1:0] sx, sy, sz;
    int unsigned       ex, ey, ez, vol, count, r;
    fill_t             fill;
    while (voxels_sent < RANDOM_VOXELS + 5000) begin
      sx = pick_extent();
      sy = pick_extent();
      sz = pick_extent();
      set_extents(sx, sy, sz);
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom);
      ex  = effective_extent(sx, DEF_MAX_X);
      ey  = effective_extent(sy, DEF_MAX_Y);
      ez  = effective_extent(sz, DEF_MAX_Z);
      vol = ex * ey * ez;
      count = vol * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) count = $urandom_range(1, vol);
      r = $urandom_range(0, 19);
      fill = (r < 9) ? FILL_BLOCKS : (r < 18) ? FILL_NOISE : FILL_RANDOM;
      tx_smooth = ($urandom_range(0, 4) == 0);
      rx_smooth = ($urandom_range(0, 4) == 0);
      stream_volume(ex, ey, ez, count, fill);
    end
    tx_smooth = 1'b0;
    rx_smooth = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_extents();
    test_single_interior();
    test_unused_index();
    test_degenerate_extents();
    test_restart_mid_volume();
    test_largest_extents();
    test_backpressure();
    test_random_volumes();
    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
